[rtl/rdbem_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdbem_pkg
// Shared codes and types for the region-decoded big-endian memory.
// ----------------------------------------------------------------------------
package rdbem_pkg;

  // access sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD       = 2'd1;
  localparam logic [1:0] ST_UNALIGNED = 2'd2;

  // region selectors, address bits 31..20
  localparam logic [11:0] SEL_PROGRAM = 12'h004;
  localparam logic [11:0] SEL_DATA    = 12'h100;
  localparam logic [11:0] SEL_STACK   = 12'h7FF;

  // region index in the store row address
  localparam logic [1:0] RG_PROGRAM = 2'd0;
  localparam logic [1:0] RG_DATA    = 2'd1;
  localparam logic [1:0] RG_STACK   = 2'd2;

  // store access control; be[3] is lane 0, the most significant byte
  typedef struct packed {
    logic       en;
    logic       we;
    logic [3:0] be;
  } mem_ctrl_t;

endpackage
`default_nettype wire

[rtl/rdbem_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdbem_store
// Byte-enabled word store for all three regions, with a clearing sweep
// after reset and a registered read port.
// ----------------------------------------------------------------------------
module rdbem_store
  import rdbem_pkg::*;
#(
  parameter int unsigned AW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mem_ctrl_t     ctrl_i,
  input  wire logic [AW-1:0] row_i,
  input  wire logic [31:0]   wdata_i,
  output logic [31:0]        rdata_o,
  output logic               busy_o
);

  localparam int unsigned Depth = 1 << AW;

  logic [31:0]   mem [Depth];
  logic [31:0]   rdata_q;
  logic          clr_q;
  logic [AW-1:0] clr_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_row_q <= '0;
    end else if (clr_q) begin
      clr_row_q <= clr_row_q + 1'b1;
      if (clr_row_q == {AW{1'b1}}) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_row_q] <= '0;
    end else if (ctrl_i.en && ctrl_i.we) begin
      for (int b = 0; b < 4; b++) begin
        if (ctrl_i.be[b]) begin
          mem[row_i][8*b +: 8] <= wdata_i[8*b +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      rdata_q <= mem[row_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

endmodule
`default_nettype wire

[rtl/region_decoded_big_endian_memory.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// region_decoded_big_endian_memory
// Program, data and stack byte regions behind one big-endian access port.
// ----------------------------------------------------------------------------
// One access per beat: accepts an item every cycle unless in_stall_o is high
// (clearing sweep or a blocked output), and carries its result through the
// stage-1 store read and then the output register. All three regions live in
// a single 32-bit wide, byte-enabled store of 2**REGION_OFFSET_BITS rows;
// each access touches exactly one row, so one store port sets the rate. After
// reset the store is swept to zero, one row a cycle, while in_stall_o is
// high. Bad regions and size three return status 1 and zero data.
module region_decoded_big_endian_memory
  import rdbem_pkg::*;
#(
  parameter int unsigned REGION_OFFSET_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [31:0] address_i,
  input  wire logic [1:0]  access_size_i,
  input  wire logic [31:0] write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      read_data_o,
  output logic [1:0]       status_o
);

  localparam int unsigned AW = REGION_OFFSET_BITS;

  // request decode
  logic                   in_acc;
  logic                   rg_ok;
  logic [1:0]             rg_idx;
  logic                   sz_ok;
  logic                   unal;
  logic [1:0]             lane;
  logic [3:0]             be;
  logic [31:0]            wword;
  logic [AW-1:0]          off;
  logic [AW-1:0]          row;
  logic                   busy;
  logic [31:0]            rdata;
  mem_ctrl_t              ctrl;

  // stage 1: store read in flight
  logic       s1_valid_q;
  logic       s1_rd_q;
  logic [1:0] s1_status_q;
  logic [1:0] s1_size_q;
  logic [1:0] s1_lane_q;
  logic       s1_adv;
  logic [31:0] s1_data;

  // output register
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic [1:0]  out_status_q;

  assign off = address_i[AW-1:0];

  always_comb begin
    rg_ok  = 1'b1;
    rg_idx = RG_PROGRAM;
    unique case (address_i[31:20])
      SEL_PROGRAM: rg_idx = RG_PROGRAM;
      SEL_DATA:    rg_idx = RG_DATA;
      SEL_STACK:   rg_idx = RG_STACK;
      default:     rg_ok  = 1'b0;
    endcase
  end

  always_comb begin
    sz_ok = 1'b1;
    unal  = 1'b0;
    lane  = 2'd0;
    be    = 4'b0000;
    wword = write_data_i;
    unique case (access_size_i)
      SZ_BYTE: begin
        lane  = off[1:0];
        be    = 4'b1000 >> off[1:0];
        wword = {4{write_data_i[7:0]}};
      end
      SZ_HALF: begin
        unal  = off[0];
        lane  = {off[1], 1'b0};
        be    = off[1] ? 4'b0011 : 4'b1100;
        wword = {2{write_data_i[15:0]}};
      end
      SZ_WORD: begin
        unal = (off[1:0] != 2'd0);
        be   = 4'b1111;
      end
      default: sz_ok = 1'b0;
    endcase
  end

  assign row = {rg_idx, off[AW-1:2]};

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy || (s1_valid_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ctrl.en = in_acc && rg_ok && sz_ok;
  assign ctrl.we = op_i;
  assign ctrl.be = be;

  rdbem_store #(
    .AW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .row_i   (row),
    .wdata_i (wword),
    .rdata_o (rdata),
    .busy_o  (busy)
  );

  // pick the addressed bytes; lane 0 is the most significant
  always_comb begin
    s1_data = '0;
    if (s1_rd_q) begin
      case (s1_size_q)
        SZ_BYTE: begin
          case (s1_lane_q)
            2'd0:    s1_data = {24'd0, rdata[31:24]};
            2'd1:    s1_data = {24'd0, rdata[23:16]};
            2'd2:    s1_data = {24'd0, rdata[15:8]};
            default: s1_data = {24'd0, rdata[7:0]};
          endcase
        end
        SZ_HALF: s1_data = s1_lane_q[1] ? {16'd0, rdata[15:0]} : {16'd0, rdata[31:16]};
        default: s1_data = rdata;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_rd_q   <= !op_i && rg_ok && sz_ok;
      s1_size_q <= access_size_i;
      s1_lane_q <= lane;
      if (!(rg_ok && sz_ok)) begin
        s1_status_q <= ST_BAD;
      end else if (unal) begin
        s1_status_q <= ST_UNALIGNED;
      end else begin
        s1_status_q <= ST_OK;
      end
    end
    if (s1_adv) begin
      out_data_q   <= s1_data;
      out_status_q <= s1_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign status_o    = out_status_q;

  // checks
  a_no_acc_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !ctrl.en)
    else $error("store access during clearing sweep");

  a_acc_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted beat lost before stage 1");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_status_q)))
    else $error("stage 1 dropped while output blocked");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_BAD) |-> (out_data_q == 32'd0))
    else $error("bad access returned data");

endmodule
`default_nettype wire

[bench/region_decoded_big_endian_memory_tb.sv]
// ----------------------------------------------------------------------------
// region_decoded_big_endian_memory_tb
// Drives byte, halfword and word reads and writes into the program, data and
// stack regions, plus bad-region and reserved-size accesses. A byte-level
// shadow of the three regions predicts every beat's read data and status.
// ----------------------------------------------------------------------------
module region_decoded_big_endian_memory_tb
  import rdbem_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          OFFSET_BITS = 16;
  localparam int          STORE_BYTES = 1 << OFFSET_BITS;
  localparam int          RANDOM_ITEMS = 550;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          MAX_REPORTS = 10;
  localparam logic        OP_READ = 1'b0;
  localparam logic        OP_WRITE = 1'b1;
  localparam logic [1:0]  SZ_RESERVED = 2'd3;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
  } mem_result_t;

  class mem_scoreboard;
    bit [7:0]    region_mem [3][STORE_BYTES];
    mem_result_t expected_q [$];
    int          failures = 0;

    function int pending();
      return expected_q.size();
    endfunction

    function void note_access(logic op, logic [31:0] addr, logic [1:0] size,
                              logic [31:0] wdata);
      mem_result_t r;
      int          rg;
      int          nb;
      int unsigned off;
      int unsigned idx;
      r.read_data = '0;
      r.status    = ST_BAD;
      rg          = -1;
      case (addr[31:20])
        SEL_PROGRAM: rg = int'(RG_PROGRAM);
        SEL_DATA:    rg = int'(RG_DATA);
        SEL_STACK:   rg = int'(RG_STACK);
        default:     rg = -1;
      endcase
      if (rg >= 0 && size != SZ_RESERVED) begin
        nb       = 1 << size;
        off      = {12'd0, addr[19:0]};
        r.status = ST_OK;
        if ((off & (nb - 1)) != 0) begin
          r.status = ST_UNALIGNED;
          off      = off & ~(nb - 1);
        end
        off = off & (STORE_BYTES - 1);
        for (int i = 0; i < nb; i++) begin
          idx = (off + i) & (STORE_BYTES - 1);
          if (op == OP_READ)
            r.read_data = {r.read_data[23:0], region_mem[rg][idx]};
          else
            region_mem[rg][idx] = 8'(wdata >> (8 * (nb - 1 - i)));
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] rdata, logic [1:0] st);
      mem_result_t e;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected beat: read_data %h status %0d", rdata, st);
        return;
      end
      e = expected_q.pop_front();
      if (rdata !== e.read_data || st !== e.status) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("mismatch: read_data exp %h got %h, status exp %0d got %0d",
                   e.read_data, rdata, e.status, st);
      end
    endfunction
  endclass

  bit          clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = OP_READ;
  logic [31:0] address_i = '0;
  logic [1:0]  access_size_i = SZ_BYTE;
  logic [31:0] write_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] read_data_o;
  logic [1:0]  status_o;

  mem_scoreboard sb = new();

  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;
  bit          alt_phase = 1'b0;
  int          cycle_count = 0;
  int          sent = 0;

  region_decoded_big_endian_memory #(
    .REGION_OFFSET_BITS(OFFSET_BITS)
  ) uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .op_i,
    .address_i,
    .access_size_i,
    .write_data_i,
    .out_valid_o,
    .out_stall_i,
    .read_data_o,
    .status_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: check accepted beats, then pick next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(read_data_o, status_o);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      alt_phase <= ~alt_phase;
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 9) < 6);
        default: out_stall_i <= alt_phase;
      endcase
    end
  end

  // present one beat and hold it until taken
  task automatic send_access(logic op, logic [31:0] addr, logic [1:0] size,
                             logic [31:0] wdata);
    in_valid_i    <= 1'b1;
    op_i          <= op;
    address_i     <= addr;
    access_size_i <= size;
    write_data_i  <= wdata;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_access(op, addr, size, wdata);
    sent++;
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_address();
    logic [11:0] sel;
    logic [19:0] off;
    int          r;
    r = $urandom_range(0, 2);
    sel = (r == 0) ? SEL_PROGRAM : (r == 1) ? SEL_DATA : SEL_STACK;
    // mostly a small window so reads land on earlier writes; top
    // offset bits alias through the wrap
    if ($urandom_range(0, 9) < 8)
      off = {4'($urandom), 10'd0, 6'($urandom)};
    else
      off = 20'($urandom);
    if ($urandom_range(0, 19) == 0)
      return $urandom;
    return {sel, off};
  endfunction

  function automatic logic [1:0] pick_size();
    int r;
    r = $urandom_range(0, 30);
    if (r == 0)
      return SZ_RESERVED;
    return 2'($urandom_range(0, 2));
  endfunction

  task automatic random_access();
    logic [31:0] addr;
    addr = pick_address();
    if ($urandom_range(0, 9) < 4) begin
      // write then read back, sizes independent
      send_access(OP_WRITE, addr, pick_size(), $urandom);
      send_access(OP_READ, addr, pick_size(), $urandom);
    end else begin
      send_access(logic'($urandom_range(0, 1)), addr, pick_size(), $urandom);
    end
  endtask

  initial begin
    int  burst;
    bit  hold_done;
    bit  pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, packing, alignment, wrap, bad region, size three
    send_access(OP_READ,  32'h0040_0000, SZ_WORD, 32'h0);
    send_access(OP_WRITE, 32'h0040_0000, SZ_WORD, 32'hDEAD_BEEF);
    send_access(OP_READ,  32'h0040_0000, SZ_WORD, 32'h0);
    send_access(OP_READ,  32'h0040_0000, SZ_BYTE, 32'h0);
    send_access(OP_READ,  32'h0040_0003, SZ_BYTE, 32'hFFFF_FFFF);
    send_access(OP_READ,  32'h0040_0002, SZ_HALF, 32'h0);
    send_access(OP_READ,  32'h0040_0001, SZ_HALF, 32'h0);
    send_access(OP_READ,  32'h0040_0003, SZ_WORD, 32'h0);
    send_access(OP_WRITE, 32'h1000_0006, SZ_HALF, 32'hFFFF_1234);
    send_access(OP_READ,  32'h1000_0004, SZ_WORD, 32'h0);
    send_access(OP_WRITE, 32'h7FFF_FFFF, SZ_BYTE, 32'hFFFF_FFA5);
    send_access(OP_READ,  32'h7FF0_FFFF, SZ_BYTE, 32'h0);
    send_access(OP_WRITE, 32'h7FFF_FFFE, SZ_WORD, 32'hFFFF_FFFF);
    send_access(OP_READ,  32'h7FF0_FFFC, SZ_WORD, 32'h0);
    send_access(OP_WRITE, 32'h0000_0000, SZ_WORD, 32'hFFFF_FFFF);
    send_access(OP_READ,  32'hFFFF_FFFF, SZ_WORD, 32'h0);
    send_access(OP_READ,  32'h0040_0000, SZ_RESERVED, 32'h0);
    send_access(OP_WRITE, 32'h1000_0000, SZ_RESERVED, 32'hFFFF_FFFF);
    send_access(OP_WRITE, 32'h2000_0000, SZ_RESERVED, 32'hFFFF_FFFF);
    send_access(OP_READ,  32'h1000_0000, SZ_WORD, 32'h0);
    send_access(OP_WRITE, 32'h100F_FFFC, SZ_WORD, 32'h0000_0000);
    send_access(OP_READ,  32'h1000_FFFC, SZ_WORD, 32'h0);
    send_access(OP_WRITE, 32'h0040_0010, SZ_HALF, 32'h0000_8001);
    send_access(OP_READ,  32'h0040_0010, SZ_WORD, 32'h0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      if (!hold_done && sent > 150) begin
        // receiver holds off; keep offering until the input backs up
        hold_done = 1'b1;
        hold_req  = 1'b1;
        burst     = 24;
      end
      repeat (burst) random_access();
      if (!pause_done && sent > 350) begin
        pause_done = 1'b1;
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 3) != 0)
        idle_cycles($urandom_range(1, 10));
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
